// File: design/stma_pkg.sv
// stma_pkg: shared types and constants for the sparse triple matrix add core
// no dependencies; imported by the channel interfaces and the top-level core

package stma_pkg;

  // field widths fixed by the channel payloads
  localparam int CMD_W    = 2;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 16;
  localparam int SUM_W    = VALUE_W + 1;
  localparam int DIM_W    = 5;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 4;

  // dimension registers come out of reset as a full-size square matrix
  localparam logic [DIM_W-1:0] MATRIX_DIM = DIM_W'(16);

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_A_ROWS = REG_W'(0);
  localparam logic [REG_W-1:0] REG_A_COLS = REG_W'(1);
  localparam logic [REG_W-1:0] REG_B_ROWS = REG_W'(2);
  localparam logic [REG_W-1:0] REG_B_COLS = REG_W'(3);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2
  } cmd_e_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_TERM     = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_DIM_MISM = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_e_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e_t;

  // one stored term, as held in a list memory
  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } term_t;

  localparam int TERM_W = $bits(term_t);

endpackage

// File: design/stma_ifs.sv
// stma_ifs: valid/ready channel interfaces for loads and runs, results and configuration
// depends on stma_pkg for the field widths

// input channel: load a term or start a run
interface stma_in_if import stma_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   term_row;
  logic [POS_W-1:0]   term_col;
  logic [VALUE_W-1:0] term_value;

  modport source (output valid, cmd, term_row, term_col, term_value, input ready);
  modport sink   (input valid, cmd, term_row, term_col, term_value, output ready);
endinterface

// result channel: merged terms, empty and error results
interface stma_out_if import stma_pkg::*;;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    out_row;
  logic [POS_W-1:0]    out_col;
  logic [SUM_W-1:0]    out_value;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, out_row, out_col, out_value, status, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

// configuration write channel
interface stma_cfg_if import stma_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] reg_index;
  logic [DIM_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: design/stma_ram.sv
// stma_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for both term lists

module stma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/sparse_triple_matrix_add_core.sv
// sparse_triple_matrix_add_core: top level, two term-list rams and the merge controller
// depends on stma_pkg, stma_ifs and stma_ram
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  in_chan   | in  | valid / ready | cmd, term_row, term_col, term_value
//  out_chan  | out | valid / ready | out_row, out_col, out_value, status, last
//  cfg_chan  | in  | valid / ready | reg_index, wdata (a_rows, a_cols, b_rows, b_cols)
//
// a load writes its term into its list ram at the transfer, or flags overflow if the list is full
// a run gives count_a + count_b result terms at most, fewer when positions coincide;
// each list ram has one registered read port, addressed with the next merge pointer
// an error or empty run gives a single result, with last set
// reset is synchronous, active low, and empties both lists; the rams need no clearing
// a stalled output holds the merge in place; no in_chan command is taken while a run is active

module sparse_triple_matrix_add_core import stma_pkg::*; #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  stma_in_if.sink    in_chan,
  stma_out_if.source out_chan,
  stma_cfg_if.sink   cfg_chan
);

  localparam int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
  localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TERMS_PER_LIST);

  state_e_t state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             ovf_r, ovf_nxt;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [SUM_W-1:0]    out_value_r, out_value_nxt;
  status_e_t           out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic  in_xfer, cfg_xfer, out_free;
  logic  we_a, we_b;
  term_t wterm, a_head, b_head;
  logic  a_left, b_left, take_a, take_b, dim_mism, run_done;
  logic [SUM_W-1:0] a_ext, b_ext, sum;

  // handshakes
  assign in_xfer        = in_chan.valid & in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign cfg_xfer       = cfg_chan.valid;
  assign out_free       = ~out_valid_r | out_chan.ready;

  // load path into the list rams
  assign wterm = '{row: in_chan.term_row, col: in_chan.term_col, value: in_chan.term_value};
  assign we_a  = in_xfer && (in_chan.cmd == CMD_LOAD_A) && (count_a_r != FULL);
  assign we_b  = in_xfer && (in_chan.cmd == CMD_LOAD_B) && (count_b_r != FULL);

  stma_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[IDX_W-1:0]),
    .wdata (wterm),
    .raddr (i_nxt[IDX_W-1:0]),
    .rdata (a_head)
  );

  stma_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[IDX_W-1:0]),
    .wdata (wterm),
    .raddr (j_nxt[IDX_W-1:0]),
    .rdata (b_head)
  );

  // head-to-head compare; ram data always belongs to the current i_r / j_r
  assign a_left   = (i_r < count_a_r);
  assign b_left   = (j_r < count_b_r);
  assign dim_mism = (a_rows_r != b_rows_r) || (a_cols_r != b_cols_r);
  assign a_ext    = {a_head.value[VALUE_W-1], a_head.value};
  assign b_ext    = {b_head.value[VALUE_W-1], b_head.value};
  assign sum      = a_ext + b_ext;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (!a_left) begin
      take_b = 1'b1;
    end else if (!b_left) begin
      take_a = 1'b1;
    end else if (a_head.row != b_head.row) begin
      take_a = (a_head.row < b_head.row);
      take_b = ~take_a;
    end else if (a_head.col != b_head.col) begin
      take_a = (a_head.col < b_head.col);
      take_b = ~take_a;
    end else begin
      take_a = 1'b1;
      take_b = 1'b1;
    end
  end

  // next state, list counters, merge pointers and result register
  always_comb begin
    state_nxt      = state_r;
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    out_valid_nxt  = out_valid_r & ~out_chan.ready;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    run_done       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_chan.cmd)
            CMD_LOAD_A: begin
              if (count_a_r != FULL) begin
                count_a_nxt = count_a_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (count_b_r != FULL) begin
                count_b_nxt = count_b_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_RUN: begin
              state_nxt = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          if (dim_mism) begin
            out_status_nxt = STS_DIM_MISM;
            run_done       = 1'b1;
          end else if (ovf_r) begin
            out_status_nxt = STS_OVERFLOW;
            run_done       = 1'b1;
          end else if (!a_left && !b_left) begin
            // only reached when both lists were empty at the start of the run
            out_status_nxt = STS_EMPTY;
            run_done       = 1'b1;
          end else begin
            out_status_nxt = STS_TERM;
            if (take_a && take_b) begin
              out_row_nxt   = b_head.row;
              out_col_nxt   = b_head.col;
              out_value_nxt = sum;
              i_nxt         = i_r + 1'b1;
              j_nxt         = j_r + 1'b1;
            end else if (take_a) begin
              out_row_nxt   = a_head.row;
              out_col_nxt   = a_head.col;
              out_value_nxt = a_ext;
              i_nxt         = i_r + 1'b1;
            end else begin
              out_row_nxt   = b_head.row;
              out_col_nxt   = b_head.col;
              out_value_nxt = b_ext;
              j_nxt         = j_r + 1'b1;
            end
            run_done     = (i_nxt >= count_a_r) && (j_nxt >= count_b_r);
            out_last_nxt = run_done;
          end
          // a finished run empties both lists
          if (run_done) begin
            state_nxt   = ST_IDLE;
            count_a_nxt = '0;
            count_b_nxt = '0;
            ovf_nxt     = 1'b0;
            i_nxt       = '0;
            j_nxt       = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= MATRIX_DIM;
      a_cols_r <= MATRIX_DIM;
      b_rows_r <= MATRIX_DIM;
      b_cols_r <= MATRIX_DIM;
    end else if (cfg_xfer) begin
      unique case (cfg_chan.reg_index)
        REG_A_ROWS: a_rows_r <= cfg_chan.wdata;
        REG_A_COLS: a_cols_r <= cfg_chan.wdata;
        REG_B_ROWS: b_rows_r <= cfg_chan.wdata;
        REG_B_COLS: b_cols_r <= cfg_chan.wdata;
        default: begin
        end
      endcase
    end
  end

  // result outputs
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_row   = out_row_r;
  assign out_chan.out_col   = out_col_r;
  assign out_chan.out_value = out_value_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.last      = out_last_r;

  // merge pointers never run past their list, and list counts never exceed the list size
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= count_a_r) && (j_r <= count_b_r) && (count_a_r <= FULL) && (count_b_r <= FULL))
    else $error("merge pointer or list count out of range");

  // error and empty results always close the run
  err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STS_TERM)) |-> out_last_r)
    else $error("error or empty result without last");

  // the end of a run leaves both lists empty, the overflow flag clear and a last result pending
  run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && state_nxt == ST_IDLE) |=>
      (count_a_r == '0 && count_b_r == '0 && !ovf_r && out_valid_r && out_last_r))
    else $error("run ended without emptying the lists");

  // overflow is only raised by a load into a full list
  ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(count_a_r == FULL || count_b_r == FULL))
    else $error("overflow flag set with room in both lists");

endmodule
